// ----- design/skvl_pkg.sv -----
package skvl_pkg;

  // Number of cells in the chain, that is, the number of pairs the table holds.
  localparam int unsigned CAPACITY = 32;
  // Width of the entry counter, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned OCC_W = 6;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [2:0] {
    KIND_INSERT    = 3'd0,
    KIND_FIND      = 3'd1,
    KIND_REMOVE    = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_DUMP_ASC  = 3'd4,
    KIND_DUMP_DESC = 3'd5
  } kind_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROT_L,
    CELL_ROT_R
  } cell_op_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  // Position of a cell relative to the occupied part of the chain.
  typedef struct packed {
    logic occ;     // cell holds a stored pair
    logic head;    // first cell of the chain
    logic tail;    // last occupied cell
    logic at_end;  // first free cell
  } cell_flags_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [KEY_W-1:0] out_key;
    logic signed [VAL_W-1:0] out_value;
    logic                    status;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } out_item_t;

endpackage

// ----- design/skvl_cell.sv -----
module skvl_cell (
  input  logic                 clk_i,
  input  skvl_pkg::cell_op_e   op_i,
  input  skvl_pkg::entry_t     new_i,
  input  skvl_pkg::cell_flags_t flags_i,
  input  skvl_pkg::entry_t     left_i,
  input  skvl_pkg::entry_t     right_i,
  input  skvl_pkg::entry_t     wrap_i,
  input  logic                 left_gt_i,
  output skvl_pkg::entry_t     entry_o,
  output logic                 gt_o,
  output logic                 eq_o
);
  import skvl_pkg::*;

  entry_t entry_q;
  entry_t entry_d;
  logic   lt;

  assign gt_o    = flags_i.occ && ($signed(entry_q.key) > $signed(new_i.key));
  assign eq_o    = flags_i.occ && (entry_q.key == new_i.key);
  assign lt      = $signed(entry_q.key) < $signed(new_i.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      CELL_INSERT: begin
        // Every cell at or after the insert point moves one place toward the tail.
        if (left_gt_i) begin
          entry_d = left_i;
        end else if (gt_o || flags_i.at_end) begin
          entry_d = new_i;
        end
      end
      CELL_REMOVE: begin
        // Cells from the first matching key on move one place toward the head.
        if (flags_i.occ && !lt) begin
          entry_d = right_i;
        end
      end
      CELL_ROT_L: begin
        if (flags_i.occ) begin
          entry_d = flags_i.tail ? wrap_i : right_i;
        end
      end
      CELL_ROT_R: begin
        if (flags_i.occ) begin
          entry_d = flags_i.head ? wrap_i : left_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- design/sorted_key_value_list_core.sv -----
// Sorted key/value table built as a chain of cells. The table holds up to
// CAPACITY signed key/value pairs in ascending key order, with equal keys kept
// in arrival order, so a new pair lands after every pair with the same key.
// Commands arrive one per input transfer: insert, find the first pair with a
// key, remove every pair with a key, clear, and dump all pairs ascending or
// descending. Each command yields one result transfer, except a dump of a
// non-empty table, which yields one transfer per stored pair, with last set
// on the final one. An insert into a full table leaves the table unchanged
// and reports status 1. Insert, find and clear pass through the execute and
// emit states before the next command can be taken. Remove stays in the
// execute state until no matching pair is left, because the chain closes one
// gap per cycle. A dump rotates the chain by one place per delivered pair and
// holds while the output stalls, so the table comes back to its original order
// after the last one. The input stalls while a command is in progress; the
// output register lets the next command in while the previous result still
// waits to be taken.
module sorted_key_value_list_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  skvl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output skvl_pkg::out_item_t out_item_o
);
  import skvl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_DUMP
  } state_e;

  state_e      state_q;
  in_item_t    cmd_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] rem_q;
  logic        pend_hit_q;
  logic        pend_status_q;
  entry_t      pend_entry_q;
  logic        out_valid_q;
  out_item_t   out_q;

  // Chain wiring.
  cell_op_e    cell_op;
  entry_t      new_entry;
  entry_t      cells   [CAPACITY];
  logic        gt      [CAPACITY];
  logic        eq      [CAPACITY];
  cell_flags_t flags   [CAPACITY];

  entry_t      found_entry;
  entry_t      tail_entry;
  logic        any_eq;
  logic        full;
  logic        out_load;
  logic        out_set;
  logic        in_accept;
  kind_e       kind;

  assign kind      = kind_e'(cmd_q.kind);
  assign new_entry = '{key: cmd_q.entry_key, value: cmd_q.entry_value};
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign out_load  = !out_valid_q || !out_stall_i;
  // A new result enters the output register in this cycle.
  assign out_set   = ((state_q == ST_EMIT) || (state_q == ST_DUMP)) && out_load;
  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    entry_t left_e;
    entry_t right_e;
    entry_t wrap_e;
    logic   left_gt;

    assign flags[i].occ    = (CNT_W'(i) < count_q);
    assign flags[i].head   = (i == 0);
    assign flags[i].tail   = (count_q != '0) && (CNT_W'(i) == (count_q - CNT_W'(1)));
    assign flags[i].at_end = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_e  = cells[i];
      assign left_gt = 1'b0;
      assign wrap_e  = tail_entry;
    end else begin : g_inner
      assign left_e  = cells[i-1];
      assign left_gt = gt[i-1];
      assign wrap_e  = cells[0];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cells[i];
    end else begin : g_next
      assign right_e = cells[i+1];
    end

    skvl_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .new_i     (new_entry),
      .flags_i   (flags[i]),
      .left_i    (left_e),
      .right_i   (right_e),
      .wrap_i    (wrap_e),
      .left_gt_i (left_gt),
      .entry_o   (cells[i]),
      .gt_o      (gt[i]),
      .eq_o      (eq[i])
    );
  end

  // Matching keys sit next to each other, so the first match is the cell whose
  // left neighbor does not match. The tail cell feeds descending dumps and the
  // wrap of a right rotation.
  always_comb begin
    found_entry = '0;
    tail_entry  = '0;
    any_eq      = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i] && ((i == 0) || !eq[(i == 0) ? 0 : i - 1])) begin
        found_entry = found_entry | cells[i];
      end
      if (flags[i].tail) begin
        tail_entry = tail_entry | cells[i];
      end
      any_eq = any_eq | eq[i];
    end
  end

  always_comb begin
    cell_op = CELL_HOLD;
    case (state_q)
      ST_EXEC: begin
        if (kind == KIND_INSERT && !full) begin
          cell_op = CELL_INSERT;
        end else if (kind == KIND_REMOVE && any_eq) begin
          cell_op = CELL_REMOVE;
        end
      end
      ST_DUMP: begin
        if (out_load) begin
          cell_op = (kind == KIND_DUMP_ASC) ? CELL_ROT_L : CELL_ROT_R;
        end
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cmd_q         <= '0;
      count_q       <= '0;
      rem_q         <= '0;
      pend_hit_q    <= 1'b0;
      pend_status_q <= 1'b0;
      pend_entry_q  <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_q   <= in_item_i;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          // Find reports the first matching pair; an insert into a full table
          // is flagged and leaves the chain alone.
          pend_hit_q    <= (kind == KIND_FIND) && any_eq;
          pend_status_q <= (kind == KIND_INSERT) && full;
          pend_entry_q  <= (kind == KIND_FIND) ? found_entry : '0;
          case (kind)
            KIND_INSERT: begin
              if (!full) begin
                count_q <= count_q + CNT_W'(1);
              end
              state_q <= ST_EMIT;
            end
            KIND_REMOVE: begin
              // One matching pair leaves the chain per cycle until none is left.
              if (any_eq) begin
                count_q <= count_q - CNT_W'(1);
              end else begin
                state_q <= ST_EMIT;
              end
            end
            KIND_CLEAR: begin
              count_q <= '0;
              state_q <= ST_EMIT;
            end
            KIND_DUMP_ASC, KIND_DUMP_DESC: begin
              rem_q   <= count_q;
              state_q <= (count_q != '0) ? ST_DUMP : ST_EMIT;
            end
            default: begin
              state_q <= ST_EMIT;
            end
          endcase
        end

        ST_EMIT: begin
          if (out_load) begin
            out_q.hit       <= pend_hit_q;
            out_q.out_key   <= pend_entry_q.key;
            out_q.out_value <= pend_entry_q.value;
            out_q.status    <= pend_status_q;
            out_q.occupancy <= OCC_W'(count_q);
            out_q.last      <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end

        ST_DUMP: begin
          // Ascending dumps read the head and rotate left, descending dumps read
          // the tail and rotate right; the chain ends up in its original order.
          if (out_load) begin
            out_q.hit       <= 1'b1;
            out_q.out_key   <= (kind == KIND_DUMP_ASC) ? cells[0].key : tail_entry.key;
            out_q.out_value <= (kind == KIND_DUMP_ASC) ? cells[0].value : tail_entry.value;
            out_q.status    <= 1'b0;
            out_q.occupancy <= OCC_W'(count_q);
            out_q.last      <= (rem_q == CNT_W'(1));
            rem_q           <= rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
